/* src/hdg_pkg.sv */
// ----------------------------------------------------------------------------
// hdg_pkg: shared types, constants and tables for the heading unit
// Holds the field widths, the CORDIC arctangent table in 2^-16 degree and the
// quadrant flags that travel down the cell chain.
// ----------------------------------------------------------------------------
package hdg_pkg;

  localparam int COORD_W  = 20;   // Q15.4 coordinates
  localparam int TOL_W    = 8;    // vertical tolerance register
  localparam int XY_W     = 32;   // CORDIC x / y datapath, signed
  localparam int ACC_W    = 25;   // angle accumulator, signed, 2^-16 degree
  localparam int ATAN_W   = 22;   // one table entry, unsigned
  localparam int CLAMP_W  = 23;   // clamped accumulator, 0 .. 90 degrees
  localparam int ANG_W    = 13;   // magnitude angle in 1/64 degree, 0 .. 5760
  localparam int HEAD_W   = 15;   // heading in 1/64 degree, 0 .. 23040
  localparam int ROUND_SH = 10;   // 2^-16 degree to 1/64 degree

  localparam int TABLE_LEN            = 24;
  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int NUDGE_LSB            = 8;
  localparam int PRESCALE             = 8;

  localparam logic [CLAMP_W-1:0] DEG90_ACC  = CLAMP_W'(5898240);
  localparam logic [HEAD_W-1:0]  DEG180_OUT = HEAD_W'(11520);
  localparam logic [HEAD_W-1:0]  DEG360_OUT = HEAD_W'(23040);

  // Quadrant and special-case flags carried alongside the CORDIC data
  typedef struct packed {
    logic above;   // end point strictly above start point
    logic right;   // end point strictly right of the nudged start
    logic vert;    // nudged dx is zero and dy is not: force 90 degrees
  } hdg_flags_t;

  // atan(2^-i) in degrees, units of 2^-16 degree, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      0:       val = ATAN_W'(2949120);
      1:       val = ATAN_W'(1740967);
      2:       val = ATAN_W'(919879);
      3:       val = ATAN_W'(466945);
      4:       val = ATAN_W'(234379);
      5:       val = ATAN_W'(117304);
      6:       val = ATAN_W'(58666);
      7:       val = ATAN_W'(29335);
      8:       val = ATAN_W'(14668);
      9:       val = ATAN_W'(7334);
      10:      val = ATAN_W'(3667);
      11:      val = ATAN_W'(1833);
      12:      val = ATAN_W'(917);
      13:      val = ATAN_W'(458);
      14:      val = ATAN_W'(229);
      15:      val = ATAN_W'(115);
      16:      val = ATAN_W'(57);
      17:      val = ATAN_W'(29);
      18:      val = ATAN_W'(14);
      19:      val = ATAN_W'(7);
      20:      val = ATAN_W'(4);
      21:      val = ATAN_W'(2);
      22:      val = ATAN_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* src/hdg_front.sv */
// ----------------------------------------------------------------------------
// hdg_front: point difference, vertical nudge and quadrant flags
// Registers the nudged |dx| and |dy|, prescaled for the CORDIC chain, plus the
// quadrant flags of one item.
// ----------------------------------------------------------------------------
module hdg_front import hdg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [TOL_W-1:0]          tol,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [XY_W-1:0]    out_x,
  output logic signed [XY_W-1:0]    out_y,
  output hdg_flags_t                out_flags
);

  logic                      vld_r, vld_nxt;
  logic signed [XY_W-1:0]    x_r, x_nxt;
  logic signed [XY_W-1:0]    y_r, y_nxt;
  hdg_flags_t                flags_r, flags_nxt;

  logic signed [COORD_W:0]   dx, dy;
  logic        [COORD_W:0]   adx, ady;
  logic signed [COORD_W+1:0] dxn, dxf;
  logic        [COORD_W:0]   ax;

  assign in_stall = vld_r && out_stall;

  always_comb begin
    dx  = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
    dy  = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
    adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    // nudge end x left by half a unit when the slope is near vertical
    dxn = $signed({dx[COORD_W], dx}) - (COORD_W+2)'(NUDGE_LSB);
    dxf = (adx <= (COORD_W+1)'(tol)) ? dxn : $signed({dx[COORD_W], dx});
    ax  = dxf[COORD_W+1] ? (COORD_W+1)'(-dxf) : (COORD_W+1)'(dxf);

    x_nxt           = $signed(XY_W'({ax, PRESCALE'(0)}));
    y_nxt           = $signed(XY_W'({ady, PRESCALE'(0)}));
    flags_nxt.above = (dy > 0);
    flags_nxt.right = (dxf > 0);
    flags_nxt.vert  = (ax == '0) && (ady != '0);

    vld_nxt = in_stall ? vld_r : in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_flags = flags_r;

endmodule

/* src/hdg_cell.sv */
// ----------------------------------------------------------------------------
// hdg_cell: one vectoring CORDIC step
// Rotates (x, y) toward the x axis by atan(2^-STEP) and updates the angle
// accumulator; hands the result to the next cell.
// ----------------------------------------------------------------------------
module hdg_cell import hdg_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [XY_W-1:0]  in_x,
  input  logic signed [XY_W-1:0]  in_y,
  input  logic signed [ACC_W-1:0] in_acc,
  input  hdg_flags_t              in_flags,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [XY_W-1:0]  out_x,
  output logic signed [XY_W-1:0]  out_y,
  output logic signed [ACC_W-1:0] out_acc,
  output hdg_flags_t              out_flags
);

  localparam logic signed [ACC_W-1:0] STEP_ANG =
    $signed({{(ACC_W-ATAN_W){1'b0}}, atan_entry(STEP)});

  logic                    vld_r, vld_nxt;
  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  hdg_flags_t              flags_r;
  logic signed [XY_W-1:0]  xs, ys;

  assign in_stall = vld_r && out_stall;

  always_comb begin
    // arithmetic shift: floor toward minus infinity
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
    if (in_y > 0) begin
      x_nxt   = in_x + ys;
      y_nxt   = in_y - xs;
      acc_nxt = in_acc + STEP_ANG;
    end else begin
      x_nxt   = in_x - ys;
      y_nxt   = in_y + xs;
      acc_nxt = in_acc - STEP_ANG;
    end
    vld_nxt = in_stall ? vld_r : in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      acc_r   <= acc_nxt;
      flags_r <= in_flags;
    end
  end

  assign out_valid = vld_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_acc   = acc_r;
  assign out_flags = flags_r;

endmodule

/* src/hdg_back.sv */
// ----------------------------------------------------------------------------
// hdg_back: clamp, round and quadrant placement
// Turns the final accumulator into a 0..90 degree magnitude in 1/64 degree,
// places it by quadrant and holds the heading in the output register.
// ----------------------------------------------------------------------------
module hdg_back import hdg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ACC_W-1:0] in_acc,
  input  hdg_flags_t              in_flags,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HEAD_W-1:0]       out_heading
);

  logic                vld_r, vld_nxt;
  logic [HEAD_W-1:0]   head_r, head_nxt;
  logic [CLAMP_W-1:0]  acc_c, acc_rnd;
  logic [ANG_W-1:0]    ang;
  logic [HEAD_W-1:0]   ang_w;

  assign in_stall = vld_r && out_stall;

  always_comb begin
    if (in_flags.vert) begin
      acc_c = DEG90_ACC;
    end else if (in_acc < 0) begin
      acc_c = '0;
    end else if (in_acc > $signed({{(ACC_W-CLAMP_W){1'b0}}, DEG90_ACC})) begin
      acc_c = DEG90_ACC;
    end else begin
      acc_c = CLAMP_W'(in_acc);
    end
    // round half up to 1/64 degree
    acc_rnd = acc_c + CLAMP_W'(1 << (ROUND_SH - 1));
    ang     = acc_rnd[ROUND_SH +: ANG_W];
    ang_w   = HEAD_W'(ang);

    if (in_flags.above) begin
      head_nxt = in_flags.right ? (DEG360_OUT - ang_w) : (DEG180_OUT + ang_w);
    end else begin
      head_nxt = in_flags.right ? ang_w : (DEG180_OUT - ang_w);
    end
    vld_nxt = in_stall ? vld_r : in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      head_r <= head_nxt;
    end
  end

  assign out_valid   = vld_r;
  assign out_heading = head_r;

endmodule

/* src/heading_angle_degrees.sv */
// The pipeline has one front stage, one CORDIC cell per iteration up to
// TABLE_LEN cells, and one output stage.
// Throughput: one item per cycle while out_stall is low; each stage holds
// its own item and fills bubbles even while the output register is stalled.
// Reset: rst_n synchronous, active low; clears all stage valids and the
// vertical tolerance register to 0.
// ----------------------------------------------------------------------------
// heading_angle_degrees: clockwise heading between two points
// Computes the heading from start to end in 1/64 degree with a pipelined
// vectoring CORDIC built as a row of step cells that differ only in STEP.
// ----------------------------------------------------------------------------
module heading_angle_degrees import hdg_pkg::*; #(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration: vertical tolerance
  input  logic                      cfg_wr_en,
  input  logic [TOL_W-1:0]          cfg_wr_data,
  // input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  // result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [HEAD_W-1:0]         out_heading
);

  // Steps beyond the table add nothing; cap the chain length at the table.
  localparam int NCELL = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;

  logic [TOL_W-1:0] tol_r;

  // Stage k feeds cell k; stage NCELL feeds the output stage.
  logic                    stg_vld   [NCELL+1];
  logic                    stg_stall [NCELL+1];
  logic signed [XY_W-1:0]  stg_x     [NCELL+1];
  logic signed [XY_W-1:0]  stg_y     [NCELL+1];
  logic signed [ACC_W-1:0] stg_acc   [NCELL+1];
  hdg_flags_t              stg_flags [NCELL+1];

  // Hold tolerance; user writes only while pipeline is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // Difference, nudge and quadrant flags.
  hdg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .tol       (tol_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .out_valid (stg_vld[0]),
    .out_stall (stg_stall[0]),
    .out_x     (stg_x[0]),
    .out_y     (stg_y[0]),
    .out_flags (stg_flags[0])
  );

  // Accumulator starts at zero degrees.
  assign stg_acc[0] = '0;

  // CORDIC cells; each advances its item one step per cycle while unstalled.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hdg_cell #(
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_vld[k]),
      .in_stall  (stg_stall[k]),
      .in_x      (stg_x[k]),
      .in_y      (stg_y[k]),
      .in_acc    (stg_acc[k]),
      .in_flags  (stg_flags[k]),
      .out_valid (stg_vld[k+1]),
      .out_stall (stg_stall[k+1]),
      .out_x     (stg_x[k+1]),
      .out_y     (stg_y[k+1]),
      .out_acc   (stg_acc[k+1]),
      .out_flags (stg_flags[k+1])
    );
  end

  // Clamp, round, place by quadrant and register the heading.
  hdg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (stg_vld[NCELL]),
    .in_stall    (stg_stall[NCELL]),
    .in_acc      (stg_acc[NCELL]),
    .in_flags    (stg_flags[NCELL]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_heading (out_heading)
  );

endmodule

/* src/hdg_checker.sv */
// ----------------------------------------------------------------------------
// hdg_checker: port-level checks for the heading unit
// Watches the top-level ports for reset, range and flow-control behavior.
// ----------------------------------------------------------------------------
module hdg_checker import hdg_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [HEAD_W-1:0]         out_heading
);

  // Reset drains every item.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Heading never exceeds 360 degrees.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading <= DEG360_OUT))
    else $error("heading above 360 degrees");

  // With the output side free the pipeline always advances.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_heading)))
    else $error("stalled result changed");

endmodule

bind heading_angle_degrees hdg_checker u_hdg_checker (.*);
